### design/cbsd_pkg.sv
// Shared types and constants for the codebook squared distance block.
`timescale 1ns / 1ps
package cbsd_pkg;
	localparam int DIM_DEF = 16;
	localparam int VOCAB_DEF = 256;
	localparam int CODE_W = 9;
	localparam int ELEM_W = 4;
	localparam int SAMPLE_W = 16;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQ_W = 33;
	localparam int DIST_W = 39;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_ACCUM = 1'b1
	} op_t;

	typedef struct packed {
		logic vld;
		logic hit;
		logic last;
	} acc_ctl_t;
endpackage

### design/cbsd_in_if.sv
// Input channel carrying codebook writes and point elements.
`timescale 1ns / 1ps
interface cbsd_in_if import cbsd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	op_t                        op;
	logic signed [CODE_W-1:0]   code_index;
	logic [ELEM_W-1:0]          elem_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last;

	modport source(output valid, op, code_index, elem_index, sample_value, last, input ready);
	modport sink(input valid, op, code_index, elem_index, sample_value, last, output ready);
endinterface

### design/cbsd_out_if.sv
// Output channel carrying the accumulated squared distance.
`timescale 1ns / 1ps
interface cbsd_out_if import cbsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;

	modport source(output valid, distance, input ready);
	modport sink(input valid, distance, output ready);
endinterface

### design/cbsd_store.sv
// Codebook memory with one write port and one registered read port.
`timescale 1ns / 1ps
module cbsd_store import cbsd_pkg::*; #(
	parameter int DEPTH = VOCAB_DEF * DIM_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [SAMPLE_W-1:0] wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [SAMPLE_W-1:0] rd_data
);
	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

### design/cbsd_mac.sv
// Difference, square and saturating accumulation of point elements.
`timescale 1ns / 1ps
module cbsd_mac import cbsd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  acc_ctl_t                   ctl_s1,
	input  logic signed [SAMPLE_W-1:0] sample_s1,
	input  logic signed [SAMPLE_W-1:0] ref_s1,
	output logic                       res_vld,
	output logic [DIST_W-1:0]          res_dist
);
	logic signed [SAMPLE_W-1:0] ref_val;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic [SQ_W-1:0]            sq_s2;
	logic                       vld_s2;
	logic                       last_s2;
	logic [DIST_W-1:0]          sum_q;
	logic [DIST_W:0]            sum_ext;
	logic [DIST_W-1:0]          sum_sat;

	always_comb begin
		ref_val = ctl_s1.hit ? ref_s1 : '0;
		diff = {sample_s1[SAMPLE_W-1], sample_s1} - {ref_val[SAMPLE_W-1], ref_val};
		prod = diff * diff;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2 <= prod[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= ctl_s1.vld;
			last_s2 <= ctl_s1.last;
		end
	end

	always_comb begin
		sum_ext = {1'b0, sum_q} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_s2};
		sum_sat = sum_ext[DIST_W] ? '1 : sum_ext[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && vld_s2) begin
			sum_q <= last_s2 ? '0 : sum_sat;
		end
	end

	assign res_vld = vld_s2 && last_s2;
	assign res_dist = sum_sat;
endmodule

### design/codebook_squared_distance.sv
// Top level of the codebook squared distance block.
// Throughput: one item per cycle, writes and point elements alike, while the output register is empty or taken.
// A last element passes the registered codebook read, the registered square and the accumulate,
// and its distance is then presented from the output register.
// Reset clears the pipeline valids, the running sum and the output valid flag.
// The codebook memory is not cleared and holds nothing usable until written.
`timescale 1ns / 1ps
module codebook_squared_distance import cbsd_pkg::*; #(
	parameter int DIM = DIM_DEF,
	parameter int NUM_CODES = VOCAB_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cbsd_in_if.sink    in_ch,
	cbsd_out_if.source out_ch
);
	localparam int DEPTH = NUM_CODES * DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                       adv;
	logic                       in_range;
	logic [AW-1:0]              addr;
	logic                       wr_en;
	logic [SAMPLE_W-1:0]        rd_data;
	acc_ctl_t                   ctl_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       res_vld;
	logic [DIST_W-1:0]          res_dist;
	logic                       out_valid_q;
	logic [DIST_W-1:0]          out_dist_q;

	assign adv = !out_valid_q || out_ch.ready;
	assign in_ch.ready = adv;

	always_comb begin
		in_range = !in_ch.code_index[CODE_W-1]
			&& (32'(in_ch.code_index[CODE_W-2:0]) < 32'(NUM_CODES))
			&& (32'(in_ch.elem_index) < 32'(DIM));
		addr = in_range
			? AW'(32'(in_ch.code_index[CODE_W-2:0]) * 32'(DIM) + 32'(in_ch.elem_index))
			: '0;
		wr_en = in_ch.valid && adv && (in_ch.op == OP_WRITE) && in_range;
	end

	cbsd_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(addr),
		.wr_data(in_ch.sample_value),
		.rd_en(adv),
		.rd_addr(addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld <= in_ch.valid && (in_ch.op == OP_ACCUM);
			ctl_s1.hit <= in_range;
			ctl_s1.last <= in_ch.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= in_ch.sample_value;
		end
	end

	cbsd_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.ctl_s1(ctl_s1),
		.sample_s1(sample_s1),
		.ref_s1(rd_data),
		.res_vld(res_vld),
		.res_dist(res_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			out_dist_q <= res_dist;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.distance = out_dist_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.op == OP_ACCUM) && in_ch.last)
			##1 in_ch.ready ##1 in_ch.ready |=> out_ch.valid)
		else $error("A last point element did not produce a distance transfer.");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(res_vld))
		else $error("A distance appeared without a last point element in the pipeline.");

	a_write_gives_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.op == OP_WRITE)) |=> !ctl_s1.vld)
		else $error("A codebook write entered the accumulate pipeline.");
endmodule

### test/cbsd_distance_checker.sv
// Checker that predicts and compares the codebook squared distance results.
`timescale 1ns / 1ps
module cbsd_distance_checker import cbsd_pkg::*; #(
	parameter int DIM = DIM_DEF,
	parameter int NUM_CODES = VOCAB_DEF
) (
	input logic  clk,
	input logic  arst_n,
	cbsd_in_if   in_ch,
	cbsd_out_if  out_ch,
	output int   errors,
	output int   outstanding
);
	localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 64'd1;

	logic signed [SAMPLE_W-1:0] codeword_mem [NUM_CODES*DIM];
	longint unsigned            running_dist;
	logic [DIST_W-1:0]          distances_due [$];

	function automatic bit names_entry(input logic signed [CODE_W-1:0] code,
		input logic [ELEM_W-1:0] elem);
		return code >= 0 && int'(code) < NUM_CODES && int'(elem) < DIM;
	endfunction

	task automatic absorb_transfer(input op_t op, input logic signed [CODE_W-1:0] code,
		input logic [ELEM_W-1:0] elem, input logic signed [SAMPLE_W-1:0] sample,
		input logic last);
		int                         slot;
		int                         diff;
		longint unsigned            mag;
		longint unsigned            total;
		logic signed [SAMPLE_W-1:0] stored;
		slot = int'(code) * DIM + int'(elem);
		if (op == OP_WRITE) begin
			if (names_entry(code, elem))
				codeword_mem[slot] = sample;
		end else begin
			stored = '0;
			if (names_entry(code, elem))
				stored = codeword_mem[slot];
			diff = int'(sample) - int'(stored);
			mag = (diff < 0) ? longint'(-diff) : longint'(diff);
			total = running_dist + mag * mag;
			running_dist = (total > DIST_MAX) ? DIST_MAX : total;
			if (last) begin
				distances_due.push_back(running_dist[DIST_W-1:0]);
				running_dist = 0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			running_dist = 0;
			distances_due.delete();
			outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (distances_due.size() == 0) begin
					$error("distance: unexpected transfer, actual %0d", out_ch.distance);
					errors++;
				end else begin
					if (out_ch.distance !== distances_due[0]) begin
						$error("distance mismatch: expected %0d, actual %0d",
							distances_due[0], out_ch.distance);
						errors++;
					end
					void'(distances_due.pop_front());
				end
			end
			if (in_ch.valid && in_ch.ready)
				absorb_transfer(in_ch.op, in_ch.code_index, in_ch.elem_index,
					in_ch.sample_value, in_ch.last);
			outstanding <= distances_due.size();
		end
	end
endmodule

### test/tb_codebook_squared_distance.sv
// Testbench top for the codebook squared distance block: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_codebook_squared_distance;
	import cbsd_pkg::*;

	localparam int DIM = DIM_DEF;
	localparam int VOCAB = VOCAB_DEF;
	localparam int ITEM_TARGET = 1600;
	localparam int CALM_FROM = 1400;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	bit   calm;
	int   gap_odds;
	int   sent;
	bit   loaded [VOCAB*DIM];
	int   loaded_slots [$];
	int   full_codes [$];

	cbsd_in_if  in_ch ();
	cbsd_out_if out_ch ();

	codebook_squared_distance #(.DIM(DIM), .NUM_CODES(VOCAB)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	cbsd_distance_checker #(.DIM(DIM), .NUM_CODES(VOCAB)) distance_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 3) != 0) begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	function automatic int rand_sample();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int rand_negative_code();
		return -int'($urandom_range(1, 256));
	endfunction

	task automatic send(input op_t op, input int code, input int elem, input int sample,
		input bit last);
		int slot;
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.op           <= op;
		in_ch.code_index   <= CODE_W'(code);
		in_ch.elem_index   <= ELEM_W'(elem);
		in_ch.sample_value <= SAMPLE_W'(sample);
		in_ch.last         <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		slot = code * DIM + elem;
		if (op == OP_WRITE && code >= 0 && code < VOCAB && elem < DIM && !loaded[slot]) begin
			loaded[slot] = 1'b1;
			loaded_slots.push_back(slot);
		end
		if (!(op == OP_WRITE && code < 0))
			sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic load_codeword(input int code, input bit fixed, input int value);
		for (int e = 0; e < DIM; e++)
			send(OP_WRITE, code, e, fixed ? value : rand_sample(), $urandom_range(0, 7) == 0);
		full_codes.push_back(code);
	endtask

	task automatic send_point_element(input int elem, input bit last);
		int slot;
		if ($urandom_range(0, 1) == 0 && loaded_slots.size() != 0) begin
			slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
			send(OP_ACCUM, slot / DIM, slot % DIM, rand_sample(), last);
		end else begin
			send(OP_ACCUM, rand_negative_code(), elem, rand_sample(), last);
		end
	endtask

	task automatic send_point();
		int len;
		int mode;
		int code;
		len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40)) : DIM;
		if ($urandom_range(0, 1) == 0)
			len = $urandom_range(1, DIM);
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			code = full_codes[$urandom_range(0, full_codes.size() - 1)];
			for (int i = 0; i < len; i++)
				send(OP_ACCUM, code, i % DIM, rand_sample(), i == len - 1);
		end else if (mode < 8) begin
			for (int i = 0; i < len; i++)
				send(OP_ACCUM, rand_negative_code(), i % DIM, rand_sample(), i == len - 1);
		end else begin
			for (int i = 0; i < len; i++)
				send_point_element($urandom_range(0, DIM - 1), i == len - 1);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 1) == 0)
				send(OP_WRITE, int'($urandom_range(0, 511)) - 256, $urandom_range(0, DIM - 1),
					rand_sample(), $urandom_range(0, 1));
			else
				send_point_element($urandom_range(0, DIM - 1), $urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		gap_odds = 0;
		sent = 0;
		in_ch.valid        <= 1'b0;
		in_ch.op           <= OP_WRITE;
		in_ch.code_index   <= '0;
		in_ch.elem_index   <= '0;
		in_ch.sample_value <= '0;
		in_ch.last         <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_WRITE, 0, 0, 32767, 1'b0);
		send(OP_WRITE, 0, 1, -32768, 1'b0);
		send(OP_WRITE, 0, 2, 0, 1'b0);
		send(OP_WRITE, 0, 3, -1, 1'b0);
		send(OP_WRITE, 255, 15, 12345, 1'b1);
		send(OP_WRITE, -1, 0, 7, 1'b1);
		send(OP_WRITE, -256, 15, -7, 1'b0);
		send(OP_ACCUM, 0, 0, -32768, 1'b0);
		send(OP_ACCUM, 0, 1, 32767, 1'b0);
		send(OP_ACCUM, 0, 2, 0, 1'b0);
		send(OP_ACCUM, 0, 3, -1, 1'b1);
		send(OP_ACCUM, -1, 5, -32768, 1'b1);
		send(OP_ACCUM, -256, 15, 32767, 1'b0);
		send(OP_ACCUM, 255, 15, -32768, 1'b1);
		send(OP_ACCUM, 0, 2, 0, 1'b1);
		send(OP_ACCUM, 0, 1, -32768, 1'b1);

		// A long point of maximal differences drives the sum into saturation.
		load_codeword(1, 1'b1, 32767);
		for (int i = 0; i < 140; i++)
			send(OP_ACCUM, 1, i % DIM, -32768, i == 139);
		send(OP_ACCUM, -1, 0, 1, 1'b1);
		wait_drained();

		while (sent < ITEM_TARGET) begin
			if (sent >= CALM_FROM)
				calm = 1'b1;
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(2, 8));
			case ($urandom_range(0, 19))
				0, 1, 2, 3: load_codeword($urandom_range(0, VOCAB - 1), 1'b0, 0);
				4, 5, 6: send_noise();
				7: wait_drained();
				default: send_point();
			endcase
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

### files.f
design/cbsd_pkg.sv
design/cbsd_in_if.sv
design/cbsd_out_if.sv
design/cbsd_store.sv
design/cbsd_mac.sv
design/codebook_squared_distance.sv
test/cbsd_distance_checker.sv
test/tb_codebook_squared_distance.sv
